[hw/rtl/crcsum_pkg.sv]
package crcsum_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [15:0] SKIP_LO      = 16'd14;
    localparam logic [15:0] SKIP_HI      = 16'd15;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [15:0] CRC_LEN_RST  = 16'd4092;
    localparam logic [15:0] SUM_LEN_RST  = 16'd4096;
    localparam int          APB_AW       = 3;
    localparam int          APB_DW       = 32;

    typedef enum logic [0:0] {
        REG_CRC_LENGTH = 1'b0,
        REG_SUM_LENGTH = 1'b1
    } reg_idx_t;

    typedef logic [7:0]  data_byte_t;
    typedef logic [31:0] crc_t;
    typedef logic [15:0] sum_t;

    function automatic crc_t crc_byte(input crc_t c_in, input data_byte_t b);
        crc_t c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/crcsum_in_if.sv]
interface crcsum_in_if;
    import crcsum_pkg::*;

    logic       valid;
    logic       ready;
    data_byte_t data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[hw/rtl/crcsum_out_if.sv]
interface crcsum_out_if;
    import crcsum_pkg::*;

    logic valid;
    logic ready;
    crc_t crc_value;
    sum_t weighted_sum;

    modport source (output valid, output crc_value, output weighted_sum, input ready);
    modport sink   (input valid, input crc_value, input weighted_sum, output ready);
endinterface

[hw/rtl/config_record_checksum_core.sv]
// Settings record checker: takes one record byte per word on byte_in and keeps a reflected
// CRC-32 (poly 0xEDB88320, start 0, inverted on output) over the first crc_length bytes and a
// 16-bit position-weighted sum over the first sum_length bytes, skipping positions 14 and 15.
// A word with last_byte set produces one result word carrying both values and clears the
// running state. One byte is taken every cycle unless the pipe stalls; each byte passes the
// input register, then the unrolled byte-wide CRC step and 8x16 multiply-add into the result
// register. The pipe only stalls when a finished result is still waiting on result_out and
// another last byte arrives. Lengths are set over APB at 0x0 (crc_length) and 0x4 (sum_length).
module config_record_checksum_core (
    input  logic                           clk,
    input  logic                           rst_n,
    crcsum_in_if.sink                      byte_in,
    crcsum_out_if.source                   result_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [crcsum_pkg::APB_AW-1:0]  paddr,
    input  logic [crcsum_pkg::APB_DW-1:0]  pwdata,
    output logic [crcsum_pkg::APB_DW-1:0]  prdata,
    output logic                           pready
);
    import crcsum_pkg::*;

    sum_t       crc_len_reg;
    sum_t       sum_len_reg;
    reg_idx_t   reg_idx;
    logic       cfg_wr;

    logic       s1_valid_reg;
    data_byte_t s1_data_reg;
    logic       s1_last_reg;

    sum_t       pos_reg;
    sum_t       pos_next;
    crc_t       crc_reg;
    crc_t       crc_next;
    sum_t       sum_reg;
    sum_t       sum_next;

    logic       out_valid_reg;
    crc_t       out_crc_reg;
    sum_t       out_sum_reg;

    logic       out_free;
    logic       s1_fire;
    logic       in_fire;
    logic [23:0] product;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx)
            REG_CRC_LENGTH: prdata = {16'd0, crc_len_reg};
            REG_SUM_LENGTH: prdata = {16'd0, sum_len_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_len_reg <= CRC_LEN_RST;
            sum_len_reg <= SUM_LEN_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_CRC_LENGTH: crc_len_reg <= pwdata[15:0];
                REG_SUM_LENGTH: sum_len_reg <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    // a last byte needs the result register; ordinary bytes never wait
    assign out_free      = !out_valid_reg || result_out.ready;
    assign s1_fire       = s1_valid_reg && (!s1_last_reg || out_free);
    assign byte_in.ready = !s1_valid_reg || s1_fire;
    assign in_fire       = byte_in.valid && byte_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            s1_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= byte_in.data_byte;
            s1_last_reg <= byte_in.last_byte;
        end
    end

    assign product = s1_data_reg * (pos_reg + 16'd1);

    always_comb
    begin
        crc_next = crc_reg;
        sum_next = sum_reg;
        pos_next = pos_reg;
        if (pos_reg < crc_len_reg)
        begin
            crc_next = crc_byte(crc_reg, s1_data_reg);
        end
        if ((pos_reg < sum_len_reg) && (pos_reg != SKIP_LO) && (pos_reg != SKIP_HI))
        begin
            sum_next = sum_reg + product[15:0];
        end
        if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= '0;
            sum_reg <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                pos_reg <= '0;
                crc_reg <= '0;
                sum_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                crc_reg <= crc_next;
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            out_crc_reg <= ~crc_next;
            out_sum_reg <= sum_next;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.crc_value    = out_crc_reg;
    assign result_out.weighted_sum = out_sum_reg;

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (pos_reg == '0 && crc_reg == '0 && sum_reg == '0))
        else $error("running state not cleared after last byte");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire && s1_last_reg))
        else $error("result appeared without a last byte");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_last_reg && pos_reg != POS_MAX) |=> pos_reg == $past(pos_reg) + 16'd1)
        else $error("byte position did not advance");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_out.ready) |-> !(s1_fire && s1_last_reg))
        else $error("pending result overwritten");
`endif

endmodule
